>>> sv/pbt_pkg.sv
// pbt_pkg: shared types and constants for the port binding table.
// Used by every module of the block; no dependencies.
package pbt_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EPH_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPH_LIMIT = 8'd1;

    localparam logic [15:0] EPH_BASE_RST  = 16'd1024;
    localparam logic [15:0] EPH_LIMIT_RST = 16'd5000;

    localparam logic [1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [1:0] MODE_BIND    = 2'd1;
    localparam logic [1:0] MODE_EPHEM   = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_IN_USE    = 3'd1;
    localparam logic [2:0] STAT_NO_PORT   = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [15:0] port;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] bound_port;
        logic [5:0]  slot;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_BIND,
        OP_EPHEM,
        OP_RELEASE
    } op_t;

    // port holds the first ephemeral candidate for OP_EPHEM
    typedef struct packed {
        op_t         op;
        logic        eph_empty;
        logic [31:0] address;
        logic [15:0] port;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [15:0] port;
    } entry_t;

    typedef enum logic [1:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_SCAN,
        ENG_DONE
    } eng_state_t;

endpackage

>>> sv/pbt_front.sv
// pbt_front: accepts request words, classifies them and queues commands.
// Depends on pbt_pkg.
module pbt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pbt_pkg::req_t req,
    input  logic [15:0]   eph_base,
    input  logic [15:0]   eph_limit,
    input  logic          clearing,
    output logic          cmd_valid,
    output pbt_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import pbt_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd_in;
    logic       accept;
    logic       take;

    always_comb
    begin
        cmd_in.address   = req.address;
        cmd_in.port      = req.port;
        cmd_in.eph_empty = (eph_base >= eph_limit);
        case (req.mode)
            MODE_LOOKUP:  cmd_in.op = OP_LOOKUP;
            MODE_BIND:    cmd_in.op = OP_BIND;
            MODE_EPHEM:
            begin
                cmd_in.op   = OP_EPHEM;
                cmd_in.port = eph_base + 16'd1;
            end
            MODE_RELEASE: cmd_in.op = OP_RELEASE;
            default:      cmd_in.op = OP_LOOKUP;
        endcase
    end

    assign full      = (cnt_reg == 2'd2) || clearing;
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign take      = cmd_take && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        case ({accept, take})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> sv/pbt_rsp_fifo.sv
// pbt_rsp_fifo: two-word result queue toward the consumer.
// Depends on pbt_pkg.
module pbt_rsp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  pbt_pkg::rsp_t wr_word,
    output logic          wr_full,
    output logic          empty,
    input  logic          pop,
    output pbt_pkg::rsp_t rsp
);
    import pbt_pkg::*;

    rsp_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;
    assign rsp     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

>>> sv/pbt_engine.sv
// pbt_engine: owns the endpoint table memory, scans it one entry per cycle
// and executes lookup, bind, ephemeral bind and release. Depends on pbt_pkg.
module pbt_engine #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  pbt_pkg::cmd_t cmd,
    output logic          cmd_take,
    input  logic [15:0]   eph_limit,
    output logic          clearing,
    output logic          rsp_push,
    output pbt_pkg::rsp_t rsp_word,
    input  logic          rsp_full
);
    import pbt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W:0]   CNT_N    = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    eng_state_t       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    rsp_t             res_reg, res_next;
    logic [16:0]      cand_reg, cand_next;
    logic [IDX_W:0]   issue_reg, issue_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             bumped_reg, bumped_next;

    logic [IDX_W-1:0] mem_rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic             is_eph;
    logic [15:0]      key;
    logic             cand_in_range;
    logic             match;
    logic             pass_done;

    function automatic logic [5:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+5:0] ext;
        ext = {6'b000000, idx};
        return ext[5:0];
    endfunction

    assign is_eph        = (cmd_reg.op == OP_EPHEM);
    assign key           = is_eph ? cand_reg[15:0] : cmd_reg.port;
    assign cand_in_range = (cand_reg <= {1'b0, eph_limit});
    assign match         = rd_data_reg.valid
                           && (rd_data_reg.address == cmd_reg.address)
                           && (rd_data_reg.port == key)
                           && (!is_eph || cand_in_range);
    assign pass_done     = (issue_reg == CNT_N) && !chk_vld_reg;
    assign clearing      = (state_reg == ENG_CLEAR);
    assign rsp_word      = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        cand_next       = cand_reg;
        issue_next      = issue_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        bumped_next     = bumped_reg;
        mem_rd_addr     = issue_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_wa          = issue_reg[IDX_W-1:0];
        mem_wd          = '0;
        cmd_take        = 1'b0;
        rsp_push        = 1'b0;

        case (state_reg)
            ENG_CLEAR:
            begin
                mem_we = 1'b1;
                if (issue_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    issue_next = '0;
                    state_next = ENG_IDLE;
                end
                else
                begin
                    issue_next = issue_reg + (IDX_W + 1)'(1);
                end
            end

            ENG_IDLE:
            begin
                cmd_take = cmd_valid;
                if (cmd_valid)
                begin
                    cmd_next        = cmd;
                    cand_next       = {1'b0, cmd.port};
                    issue_next      = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    bumped_next     = 1'b0;
                    if (cmd.op == OP_EPHEM && cmd.eph_empty)
                    begin
                        res_next   = '{status: STAT_NO_PORT, bound_port: 16'd0, slot: 6'd0};
                        state_next = ENG_DONE;
                    end
                    else
                    begin
                        state_next = ENG_SCAN;
                    end
                end
            end

            ENG_SCAN:
            begin
                if (issue_reg != CNT_N)
                begin
                    issue_next   = issue_reg + (IDX_W + 1)'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = issue_reg[IDX_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                    end
                    if (match && is_eph)
                    begin
                        cand_next   = cand_reg + 17'd1;
                        bumped_next = 1'b1;
                    end
                    if (!rd_data_reg.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                if (pass_done)
                begin
                    state_next = ENG_DONE;
                    case (cmd_reg.op)
                        OP_LOOKUP:
                        begin
                            if (hit_found_reg)
                                res_next = '{status: STAT_OK, bound_port: cmd_reg.port,
                                             slot: to_slot(hit_idx_reg)};
                            else
                                res_next = '{status: STAT_NOT_FOUND,
                                             bound_port: cmd_reg.port, slot: 6'd0};
                        end
                        OP_BIND:
                        begin
                            if (hit_found_reg)
                            begin
                                res_next = '{status: STAT_IN_USE, bound_port: cmd_reg.port,
                                             slot: to_slot(hit_idx_reg)};
                            end
                            else if (free_found_reg)
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = free_idx_reg;
                                mem_wd   = '{valid: 1'b1, address: cmd_reg.address,
                                             port: cmd_reg.port};
                                res_next = '{status: STAT_OK, bound_port: cmd_reg.port,
                                             slot: to_slot(free_idx_reg)};
                            end
                            else
                            begin
                                res_next = '{status: STAT_FULL, bound_port: cmd_reg.port,
                                             slot: 6'd0};
                            end
                        end
                        OP_EPHEM:
                        begin
                            if (!cand_in_range)
                            begin
                                res_next = '{status: STAT_NO_PORT, bound_port: 16'd0,
                                             slot: 6'd0};
                            end
                            else if (bumped_reg)
                            begin
                                // candidate moved this pass: rescan to confirm it is free
                                state_next  = ENG_SCAN;
                                issue_next  = '0;
                                bumped_next = 1'b0;
                            end
                            else if (free_found_reg)
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = free_idx_reg;
                                mem_wd   = '{valid: 1'b1, address: cmd_reg.address,
                                             port: cand_reg[15:0]};
                                res_next = '{status: STAT_OK, bound_port: cand_reg[15:0],
                                             slot: to_slot(free_idx_reg)};
                            end
                            else
                            begin
                                res_next = '{status: STAT_FULL, bound_port: 16'd0,
                                             slot: 6'd0};
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (hit_found_reg)
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = hit_idx_reg;
                                mem_wd   = '0;
                                res_next = '{status: STAT_OK, bound_port: cmd_reg.port,
                                             slot: to_slot(hit_idx_reg)};
                            end
                            else
                            begin
                                res_next = '{status: STAT_NOT_FOUND,
                                             bound_port: cmd_reg.port, slot: 6'd0};
                            end
                        end
                        default:
                        begin
                            res_next = '{status: STAT_NOT_FOUND, bound_port: cmd_reg.port,
                                         slot: 6'd0};
                        end
                    endcase
                end
            end

            ENG_DONE:
            begin
                if (!rsp_full)
                begin
                    rsp_push   = 1'b1;
                    state_next = ENG_IDLE;
                end
            end

            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ENG_CLEAR;
            issue_reg      <= '0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            bumped_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            chk_vld_reg    <= chk_vld_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            bumped_reg     <= bumped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        cand_reg     <= cand_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_rd_addr];
    end

`ifndef SYNTH
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ENG_CLEAR || state_reg == ENG_SCAN))
        else $error("table written outside clear or scan");

    a_bind_free: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_wd.valid) |-> free_found_reg)
        else $error("entry bound without a free slot found");

    a_cand_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ENG_SCAN && $past(state_reg) == ENG_SCAN)
        |-> (cand_reg == $past(cand_reg) || cand_reg == $past(cand_reg) + 17'd1))
        else $error("ephemeral candidate jumped");

    a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |=> (state_reg == ENG_IDLE))
        else $error("engine not idle after result");
`endif

endmodule

>>> sv/port_binding_table.sv
// port_binding_table: table of bound (IPv4 address, port) endpoints.
// Request words enter through push/full, result words leave through empty/pop.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 ephemeral_base,
// 1 ephemeral_limit, others ignored) and cfg_data; cfg_ready is always high.
// Each request gives one result word (status, bound_port, slot).
// Lookup, bind and release scan the table once through its single read port.
// An ephemeral bind repeats the scan until a full pass leaves the candidate
// port unchanged or the candidate passes ephemeral_limit, with at most
// TABLE_ENTRIES + 1 passes; an empty range is answered without a scan.
// One request is executed at a time, so a new one starts only after the
// previous result has been handed to the result queue; two more wait in the
// request queue and up to two results wait in the result queue, so a stalled
// consumer only stops execution once both result slots are taken.
// After reset the table is cleared one entry per cycle; full stays high during
// that sweep. Registers return to 1024 and 5000.
// Depends on pbt_pkg, pbt_front, pbt_engine and pbt_rsp_fifo.
module port_binding_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  pbt_pkg::req_t                  req,
    output logic                           empty,
    input  logic                           pop,
    output pbt_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import pbt_pkg::*;

    logic [15:0] eph_base_reg, eph_base_next;
    logic [15:0] eph_limit_reg, eph_limit_next;
    logic        cfg_wr;
    logic        clearing;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_take;
    logic        rsp_push;
    rsp_t        rsp_word;
    logic        rsp_full;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        eph_base_next  = eph_base_reg;
        eph_limit_next = eph_limit_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_EPH_BASE:  eph_base_next  = cfg_data;
                CFG_EPH_LIMIT: eph_limit_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eph_base_reg  <= EPH_BASE_RST;
            eph_limit_reg <= EPH_LIMIT_RST;
        end
        else
        begin
            eph_base_reg  <= eph_base_next;
            eph_limit_reg <= eph_limit_next;
        end
    end

    pbt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .eph_base  (eph_base_reg),
        .eph_limit (eph_limit_reg),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    pbt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .eph_limit (eph_limit_reg),
        .clearing  (clearing),
        .rsp_push  (rsp_push),
        .rsp_word  (rsp_word),
        .rsp_full  (rsp_full)
    );

    pbt_rsp_fifo u_rsp_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rsp_push),
        .wr_word (rsp_word),
        .wr_full (rsp_full),
        .empty   (empty),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

>>> bench/port_binding_table_checker.sv
`timescale 1ns / 1ps
// port_binding_table_checker: watches the request, result and register write channels,
// predicts each result word from its own copy of the endpoint table and compares.
// Depends on pbt_pkg.
module port_binding_table_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  pbt_pkg::req_t                  req,
    input  logic                           empty,
    input  logic                           pop,
    input  pbt_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output int                             fail_count,
    output int                             outstanding
);

    import pbt_pkg::*;

    logic        bound_valid [TABLE_ENTRIES];
    logic [31:0] bound_addr  [TABLE_ENTRIES];
    logic [15:0] bound_port  [TABLE_ENTRIES];
    logic [15:0] eph_base  = EPH_BASE_RST;
    logic [15:0] eph_limit = EPH_LIMIT_RST;
    rsp_t        expected_words[$];
    int          mismatches = 0;

    assign fail_count = mismatches;

    function automatic int slot_of_pair(input logic [31:0] a, input logic [15:0] p);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (bound_valid[i] && bound_addr[i] == a && bound_port[i] == p)
                return i;
        end
        return -1;
    endfunction

    function automatic int lowest_free_slot();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!bound_valid[i])
                return i;
        end
        return -1;
    endfunction

    function automatic void claim(input int s, input logic [31:0] a, input logic [15:0] p);
        bound_valid[s] = 1'b1;
        bound_addr[s]  = a;
        bound_port[s]  = p;
    endfunction

    // Applies one request to the table and returns the word it yields.
    function automatic rsp_t serve_request(input req_t r);
        rsp_t o;
        int   hit;
        int   fr;
        int   cand;
        hit          = slot_of_pair(r.address, r.port);
        fr           = lowest_free_slot();
        o.status     = STAT_OK;
        o.bound_port = r.port;
        o.slot       = '0;
        case (r.mode)
            MODE_LOOKUP:
            begin
                if (hit >= 0)
                    o.slot = 6'(hit);
                else
                    o.status = STAT_NOT_FOUND;
            end
            MODE_BIND:
            begin
                if (hit >= 0)
                begin
                    o.status = STAT_IN_USE;
                    o.slot   = 6'(hit);
                end
                else if (fr < 0)
                    o.status = STAT_FULL;
                else
                begin
                    claim(fr, r.address, r.port);
                    o.slot = 6'(fr);
                end
            end
            MODE_EPHEM:
            begin
                o.bound_port = '0;
                cand = int'(eph_base) + 1;
                while (cand <= int'(eph_limit) && slot_of_pair(r.address, 16'(cand)) >= 0)
                    cand++;
                if (cand > int'(eph_limit))
                    o.status = STAT_NO_PORT;
                else if (fr < 0)
                    o.status = STAT_FULL;
                else
                begin
                    claim(fr, r.address, 16'(cand));
                    o.bound_port = 16'(cand);
                    o.slot       = 6'(fr);
                end
            end
            default:
            begin
                if (hit >= 0)
                begin
                    bound_valid[hit] = 1'b0;
                    o.slot = 6'(hit);
                end
                else
                    o.status = STAT_NOT_FOUND;
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_word;
        if (!rst_n)
        begin
            foreach (bound_valid[i])
                bound_valid[i] = 1'b0;
            eph_base  = EPH_BASE_RST;
            eph_limit = EPH_LIMIT_RST;
            expected_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no request waiting");
                    mismatches++;
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    if (rsp.status !== exp_word.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_word.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.bound_port !== exp_word.bound_port)
                    begin
                        $error("bound_port: expected %0d, got %0d",
                               exp_word.bound_port, rsp.bound_port);
                        mismatches++;
                    end
                    if (rsp.slot !== exp_word.slot)
                    begin
                        $error("slot: expected %0d, got %0d", exp_word.slot, rsp.slot);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EPH_BASE)
                    eph_base = cfg_data;
                else if (cfg_index == CFG_EPH_LIMIT)
                    eph_limit = cfg_data;
            end
            if (push && !full)
                expected_words = {expected_words, serve_request(req)};
            outstanding <= expected_words.size();
        end
    end

endmodule

>>> bench/port_binding_table_tb.sv
`timescale 1ns / 1ps
// port_binding_table_tb: drives requests and register writes into the port binding
// table with random idling on both sides; the checker judges every result word.
// Depends on pbt_pkg, port_binding_table and port_binding_table_checker.
module port_binding_table_tb;

    import pbt_pkg::*;

    localparam int TABLE_ENTRIES   = 64;
    localparam int LIMIT_CYCLES    = 40_000_000;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int DRAIN_CYCLES    = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFF;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
    } endpoint_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    req_t                 req_word  = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    rsp_t                 rsp_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;
    int                   fail_count;
    int                   outstanding;

    bit          calm           = 1'b0;
    bit          stall_receiver = 1'b0;
    int          sent_words     = 0;
    logic [15:0] cur_base       = EPH_BASE_RST;
    logic [15:0] cur_limit      = EPH_LIMIT_RST;
    logic [31:0] addr_pool[4];
    endpoint_t   bound_log[$];

    port_binding_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req_word),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    port_binding_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req         (req_word),
        .empty       (empty),
        .pop         (pop),
        .rsp         (rsp_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[port_binding_table] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    initial
    begin : receiver
        int idle_left;
        bit held_off;
        idle_left = 0;
        held_off  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_receiver && !held_off)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            else if (idle_left > 0)
            begin
                pop <= 1'b0;
                idle_left--;
            end
            else
            begin
                pop <= 1'b1;
                idle_left = calm ? 0 : pick_gap();
            end
        end
    end

    task automatic send_word(input req_t w);
        int g;
        push     <= 1'b1;
        req_word <= w;
        do @(posedge clk); while (full);
        sent_words++;
        g = calm ? 0 : pick_gap();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] m, input logic [31:0] a, input logic [15:0] p);
        req_t w;
        w.mode    = m;
        w.address = a;
        w.port    = p;
        send_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(input logic [15:0] b, input logic [15:0] l);
        write_reg(CFG_EPH_BASE, b);
        write_reg(CFG_EPH_LIMIT, l);
        cur_base  = b;
        cur_limit = l;
    endtask

    function automatic logic [31:0] pool_addr();
        if ($urandom_range(0, 99) < 80)
            return addr_pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function automatic logic [15:0] near_port();
        return 16'(int'(cur_base) + 1 + $urandom_range(0, 70));
    endfunction

    function automatic logic [15:0] fresh_port();
        if ($urandom_range(0, 99) < 65)
            return near_port();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void log_endpoint(input logic [31:0] a, input logic [15:0] p);
        endpoint_t e;
        e.address = a;
        e.port    = p;
        bound_log = {bound_log, e};
        if (bound_log.size() > 200)
            void'(bound_log.pop_front());
    endfunction

    function automatic endpoint_t pick_endpoint(input bit consume);
        endpoint_t e;
        int        idx;
        if (bound_log.size() > 0 && $urandom_range(0, 99) < 70)
        begin
            idx = $urandom_range(0, bound_log.size() - 1);
            e   = bound_log[idx];
            if (consume)
                bound_log.delete(idx);
        end
        else
        begin
            e.address = pool_addr();
            e.port    = fresh_port();
        end
        return e;
    endfunction

    task automatic mixed_block(input int n);
        int          r;
        endpoint_t   e;
        logic [31:0] a;
        logic [15:0] p;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                e = pick_endpoint(1'b0);
                issue(MODE_LOOKUP, e.address, e.port);
            end
            else if (r < 45)
            begin
                a = pool_addr();
                p = fresh_port();
                issue(MODE_BIND, a, p);
                log_endpoint(a, p);
            end
            else if (r < 65)
            begin
                a = pool_addr();
                issue(MODE_EPHEM, a, 16'($urandom));
                log_endpoint(a, 16'(int'(cur_base) + 1 + $urandom_range(0, 3)));
            end
            else
            begin
                e = pick_endpoint(1'b1);
                issue(MODE_RELEASE, e.address, e.port);
            end
        end
    endtask

    // Many binds on one address: exhausts small ranges and fills the table.
    task automatic fill_block();
        logic [31:0] fa;
        logic [15:0] p;
        int          k;
        fa = pool_addr();
        k  = 0;
        repeat (70)
        begin
            if ($urandom_range(0, 1))
            begin
                issue(MODE_EPHEM, fa, 16'($urandom));
                log_endpoint(fa, 16'(int'(cur_base) + 1 + k));
                k++;
            end
            else
            begin
                p = near_port();
                issue(MODE_BIND, fa, p);
                log_endpoint(fa, p);
            end
        end
    endtask

    task automatic drain_block();
        endpoint_t e;
        int        n;
        n = 0;
        while (bound_log.size() > 0 && n < 80)
        begin
            e = bound_log.pop_front();
            issue(MODE_RELEASE, e.address, e.port);
            n++;
        end
        repeat (10)
            issue(MODE_RELEASE, pool_addr(), near_port());
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        int r;
        stop_at = sent_words + n;
        while (sent_words < stop_at)
        begin
            r    = $urandom_range(0, 99);
            calm = ($urandom_range(0, 4) == 0);
            if (r < 70)
                mixed_block(30);
            else if (r < 85)
                fill_block();
            else
                drain_block();
        end
        calm = 1'b0;
    endtask

    initial
    begin : stimulus
        int b;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = $urandom;
        addr_pool[3] = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset range 1024..5000
        issue(MODE_LOOKUP,  32'h0000_0000, 16'h0000);
        issue(MODE_BIND,    32'h0000_0000, 16'h0000);
        issue(MODE_BIND,    32'h0000_0000, 16'h0000);
        issue(MODE_LOOKUP,  32'h0000_0000, 16'h0000);
        issue(MODE_BIND,    32'hFFFF_FFFF, 16'hFFFF);
        issue(MODE_LOOKUP,  32'hFFFF_FFFF, 16'h0000);
        issue(MODE_EPHEM,   32'h0000_0000, 16'hFFFF);
        issue(MODE_BIND,    32'h0000_0000, 16'd1026);
        issue(MODE_EPHEM,   32'h0000_0000, 16'h0000);
        issue(MODE_EPHEM,   32'hFFFF_FFFF, 16'($urandom));
        issue(MODE_RELEASE, 32'h0000_0000, 16'h0000);
        issue(MODE_RELEASE, 32'h0000_0000, 16'h0000);
        issue(MODE_BIND,    32'h0A0B_0C0D, 16'd80);
        issue(MODE_RELEASE, $urandom,      16'($urandom));
        issue(MODE_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);
        issue(MODE_LOOKUP,  32'h0A0B_0C0D, 16'd80);

        stall_receiver = 1'b1;
        run_phase(200);

        set_range(16'd100, 16'd103);
        run_phase(200);
        set_range(16'd0, 16'd65535);
        run_phase(200);
        set_range(16'd65535, 16'd65535);
        write_reg(CFG_IDX_SPARE, 16'($urandom));
        run_phase(150);
        set_range(16'd0, 16'd0);
        run_phase(80);
        set_range(16'd5000, 16'd1024);
        run_phase(150);
        set_range(16'd65534, 16'd65535);
        run_phase(200);
        repeat (3)
        begin
            b = $urandom_range(0, 65535);
            set_range(16'(b), 16'((b + 80 > 65535) ? 65535 : b + $urandom_range(0, 80)));
            run_phase(170);
        end

        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[port_binding_table] OK");
        else
            $display("[port_binding_table] ERROR");
        $finish;
    end

endmodule
